[design/rpa_pkg.sv]
// Shared types, constants, sine table and saturation helper for the axis rotation pipeline.
package rpa_pkg;

  localparam int COORD_W        = 32;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int PROD_W         = DIFF_W + TRIG_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int SHR_W          = SUM_W - TRIG_FRAC_BITS;
  localparam int RES_W          = SHR_W + 1;
  localparam int ANG_W          = 9;
  localparam int QIDX_W         = 7;
  localparam int KIND_W         = 2;
  localparam int PIPE_DEPTH     = 5;
  localparam int IN_DATA_W      = 208;
  localparam int OUT_DATA_W     = 96;

  localparam int unsigned HALF_TURN = 180;
  localparam int unsigned FULL_TURN = 2 * HALF_TURN;
  localparam int unsigned QUARTER   = HALF_TURN / 2;
  localparam logic [63:0] PI_Q32    = 64'd13493037705;

  // Divisors (2k)(2k+1) of the Taylor terms for k = 1..12.
  localparam logic [12:1][9:0] TAYLOR_DIV = {10'd600, 10'd506, 10'd420, 10'd342, 10'd272,
                                             10'd210, 10'd156, 10'd110, 10'd72, 10'd42,
                                             10'd20, 10'd6};

  localparam logic signed [TRIG_W-1:0] TRIG_ONE   = TRIG_W'(1) << TRIG_FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  typedef enum logic [KIND_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic                      sat;
    logic signed [COORD_W-1:0] val;
  } coord_t;

  typedef logic [QUARTER:0][TRIG_W-1:0] sin_tbl_t;

  // Sine of r degrees for r in 0..90, from a truncated Taylor series in Q31 fixed point, rounded to 15 fraction bits.
  function automatic logic [TRIG_W-1:0] quarter_sin(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(r) * PI_Q32 + 64'(HALF_TURN)) / 64'(FULL_TURN);
    x2   = (x * x) >> 31;
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 31;
      term = term / 64'(TAYLOR_DIV[k]);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return TRIG_W'((sum + (64'(1) << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
  endfunction

  function automatic sin_tbl_t build_sin_tbl();
    sin_tbl_t t;
    for (int unsigned i = 0; i <= QUARTER; i++) begin
      t[i] = quarter_sin(i);
    end
    return t;
  endfunction

  localparam sin_tbl_t SIN_TBL = build_sin_tbl();

  // Clips a widened coordinate to the signed 32-bit range.
  function automatic coord_t sat_coord(input logic signed [RES_W-1:0] v);
    coord_t res;
    if ((&v[RES_W-1:COORD_W-1]) || !(|v[RES_W-1:COORD_W-1])) begin
      res.sat = 1'b0;
      res.val = v[COORD_W-1:0];
    end else begin
      res.sat = 1'b1;
      res.val = v[RES_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[design/rpa_trig.sv]
// Two-stage sine and cosine lookup for a whole-degree angle.
module rpa_trig
  import rpa_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [ANG_W-1:0] angle,
  output trig_t            trig
);

  typedef struct packed {
    logic [1:0]        q;
    logic [QIDX_W-1:0] r;
  } quad_t;

  function automatic quad_t split_angle(input logic [ANG_W:0] a);
    quad_t res;
    if (a >= (ANG_W+1)'(3 * QUARTER)) begin
      res.q = 2'd3;
      res.r = QIDX_W'(a - (ANG_W+1)'(3 * QUARTER));
    end else if (a >= (ANG_W+1)'(HALF_TURN)) begin
      res.q = 2'd2;
      res.r = QIDX_W'(a - (ANG_W+1)'(HALF_TURN));
    end else if (a >= (ANG_W+1)'(QUARTER)) begin
      res.q = 2'd1;
      res.r = QIDX_W'(a - (ANG_W+1)'(QUARTER));
    end else begin
      res.q = 2'd0;
      res.r = QIDX_W'(a);
    end
    return res;
  endfunction

  function automatic logic signed [TRIG_W-1:0] lookup(input quad_t qr);
    logic [QIDX_W-1:0]        idx;
    logic signed [TRIG_W-1:0] v;
    idx = qr.q[0] ? (QIDX_W'(QUARTER) - qr.r) : qr.r;
    v   = SIN_TBL[idx];
    return qr.q[1] ? -v : v;
  endfunction

  logic [ANG_W:0] sin_ang;
  logic [ANG_W:0] cos_ang;
  logic [ANG_W:0] cos_raw;
  quad_t          sin_qr_r;
  quad_t          cos_qr_r;
  quad_t          sin_qr_nxt;
  quad_t          cos_qr_nxt;
  trig_t          trig_r;
  trig_t          trig_nxt;

  always_comb begin
    sin_ang    = (angle >= ANG_W'(FULL_TURN)) ? (ANG_W+1)'(angle - ANG_W'(FULL_TURN))
                                               : (ANG_W+1)'(angle);
    cos_raw    = sin_ang + (ANG_W+1)'(QUARTER);
    cos_ang    = (cos_raw >= (ANG_W+1)'(FULL_TURN)) ? cos_raw - (ANG_W+1)'(FULL_TURN) : cos_raw;
    sin_qr_nxt = split_angle(sin_ang);
    cos_qr_nxt = split_angle(cos_ang);
    trig_nxt.s = lookup(sin_qr_r);
    trig_nxt.c = lookup(cos_qr_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_qr_r <= sin_qr_nxt;
      cos_qr_r <= cos_qr_nxt;
      trig_r   <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

[design/rpa_mac.sv]
// Two-stage multiply and add that forms the rotated pair with rounding bias.
module rpa_mac
  import rpa_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  trig_t                    trig,
  input  logic                     bypass,
  input  logic signed [DIFF_W-1:0] m,
  input  logic signed [DIFF_W-1:0] n,
  output logic signed [SUM_W-1:0]  p_sum,
  output logic signed [SUM_W-1:0]  q_sum
);

  logic signed [TRIG_W-1:0] s_eff;
  logic signed [TRIG_W-1:0] c_eff;
  logic signed [PROD_W-1:0] cm_r;
  logic signed [PROD_W-1:0] sn_r;
  logic signed [PROD_W-1:0] sm_r;
  logic signed [PROD_W-1:0] cn_r;
  logic signed [SUM_W-1:0]  p_r;
  logic signed [SUM_W-1:0]  q_r;
  logic signed [SUM_W-1:0]  p_nxt;
  logic signed [SUM_W-1:0]  q_nxt;

  always_comb begin
    s_eff = bypass ? '0 : trig.s;
    c_eff = bypass ? TRIG_ONE : trig.c;
    p_nxt = SUM_W'(cm_r) - SUM_W'(sn_r) + ROUND_HALF;
    q_nxt = SUM_W'(sm_r) + SUM_W'(cn_r) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r <= PROD_W'(c_eff) * PROD_W'(m);
      sn_r <= PROD_W'(s_eff) * PROD_W'(n);
      sm_r <= PROD_W'(s_eff) * PROD_W'(m);
      cn_r <= PROD_W'(c_eff) * PROD_W'(n);
      p_r  <= p_nxt;
      q_r  <= q_nxt;
    end
  end

  assign p_sum = p_r;
  assign q_sum = q_r;

endmodule

[design/rotate_point_about_axis_top.sv]
// Top level of the five-stage point rotation pipeline about a principal axis.
//
//   Channel | Direction | Handshake         | Contents
//   in_     | input     | tvalid / tready   | tdata: point, pivot, angle; tuser: axis
//   out_    | output    | tvalid / tready   | tdata: rotated point; tuser: saturated
//
// A word passes five register stages, the last being the output register, and one word can
// enter every cycle while the output register is empty or being read. The depth is set by
// the angle split, the table lookup, the 33x17 multipliers, the rounding adders and the
// final pivot add with clipping.
// All stages advance together whenever the output register is empty or being read.
// Reset clears only the stage valid bits.
module rotate_point_about_axis_top
  import rpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_x, point_y, point_z, pivot_x, pivot_y, pivot_z, angle_deg, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [OUT_DATA_W-1:0] out_tdata,
  // saturated
  output logic                  out_tuser
);

  logic                      en;
  logic [PIPE_DEPTH-1:0]     vld_r;
  vec3_t                     pnt_in;
  vec3_t                     piv_in;
  logic [ANG_W-1:0]          ang_in;

  logic signed [DIFF_W-1:0]  dx_r;
  logic signed [DIFF_W-1:0]  dy_r;
  logic signed [DIFF_W-1:0]  dz_r;
  axis_t                     kind_r [4];
  vec3_t                     piv_r  [4];
  logic signed [DIFF_W-1:0]  w_r    [3];
  logic signed [DIFF_W-1:0]  m_r;
  logic signed [DIFF_W-1:0]  n_r;
  logic signed [DIFF_W-1:0]  m_nxt;
  logic signed [DIFF_W-1:0]  n_nxt;
  logic signed [DIFF_W-1:0]  w_nxt;

  trig_t                     trig;
  logic signed [SUM_W-1:0]   p_sum;
  logic signed [SUM_W-1:0]   q_sum;

  logic signed [SHR_W-1:0]   p_shr;
  logic signed [SHR_W-1:0]   q_shr;
  logic signed [RES_W-1:0]   p_res;
  logic signed [RES_W-1:0]   q_res;
  logic signed [RES_W-1:0]   w_res;
  logic signed [RES_W-1:0]   rx;
  logic signed [RES_W-1:0]   ry;
  logic signed [RES_W-1:0]   rz;
  coord_t                    ox_nxt;
  coord_t                    oy_nxt;
  coord_t                    oz_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_sat_r;

  assign en        = !vld_r[PIPE_DEPTH-1] || out_tready;
  assign in_tready = en;

  assign pnt_in.x = in_tdata[31:0];
  assign pnt_in.y = in_tdata[63:32];
  assign pnt_in.z = in_tdata[95:64];
  assign piv_in.x = in_tdata[127:96];
  assign piv_in.y = in_tdata[159:128];
  assign piv_in.z = in_tdata[191:160];
  assign ang_in   = in_tdata[200:192];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_comb begin
    case (kind_r[0])
      AXIS_X: begin
        m_nxt = dy_r;
        n_nxt = dz_r;
        w_nxt = dx_r;
      end
      AXIS_Y: begin
        m_nxt = dz_r;
        n_nxt = dx_r;
        w_nxt = dy_r;
      end
      default: begin
        m_nxt = dx_r;
        n_nxt = dy_r;
        w_nxt = dz_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= DIFF_W'(pnt_in.x) - DIFF_W'(piv_in.x);
      dy_r      <= DIFF_W'(pnt_in.y) - DIFF_W'(piv_in.y);
      dz_r      <= DIFF_W'(pnt_in.z) - DIFF_W'(piv_in.z);
      kind_r[0] <= axis_t'(in_tuser);
      piv_r[0]  <= piv_in;
      m_r       <= m_nxt;
      n_r       <= n_nxt;
      w_r[0]    <= w_nxt;
      for (int i = 1; i < 4; i++) begin
        kind_r[i] <= kind_r[i-1];
        piv_r[i]  <= piv_r[i-1];
      end
      for (int i = 1; i < 3; i++) begin
        w_r[i] <= w_r[i-1];
      end
    end
  end

  rpa_trig u_trig (
    .clk   (clk),
    .en    (en),
    .angle (ang_in),
    .trig  (trig)
  );

  rpa_mac u_mac (
    .clk    (clk),
    .en     (en),
    .trig   (trig),
    .bypass (kind_r[1] == AXIS_NONE),
    .m      (m_r),
    .n      (n_r),
    .p_sum  (p_sum),
    .q_sum  (q_sum)
  );

  always_comb begin
    p_shr = SHR_W'(p_sum >>> TRIG_FRAC_BITS);
    q_shr = SHR_W'(q_sum >>> TRIG_FRAC_BITS);
    p_res = RES_W'(p_shr);
    q_res = RES_W'(q_shr);
    w_res = RES_W'(w_r[2]);
    case (kind_r[3])
      AXIS_X: begin
        rx = w_res;
        ry = p_res;
        rz = q_res;
      end
      AXIS_Y: begin
        rx = q_res;
        ry = w_res;
        rz = p_res;
      end
      default: begin
        rx = p_res;
        ry = q_res;
        rz = w_res;
      end
    endcase
    ox_nxt = sat_coord(rx + RES_W'(piv_r[3].x));
    oy_nxt = sat_coord(ry + RES_W'(piv_r[3].y));
    oz_nxt = sat_coord(rz + RES_W'(piv_r[3].z));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {oz_nxt.val, oy_nxt.val, ox_nxt.val};
      out_sat_r  <= ox_nxt.sat | oy_nxt.sat | oz_nxt.sat;
    end
  end

  assign out_tvalid = vld_r[PIPE_DEPTH-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule
